// ===== hw/rtl/nfv5_pkg.sv =====
`timescale 1ns / 1ps
// nfv5_pkg: shared constants, field codes and queue entry type for the
// netflow v5 record parser; no dependencies
package nfv5_pkg;

    localparam int MaxRecords = 30;
    localparam int HdrBytes   = 24;
    localparam int RecBytes   = 48;
    localparam int NfVersion  = 5;
    localparam int OffW       = $clog2(RecBytes);
    localparam int QueueDepth = 4;

    // which result field a record byte shifts into
    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_SRC_ADDR,
        FLD_DST_ADDR,
        FLD_OCTETS,
        FLD_SRC_PORT,
        FLD_DST_PORT,
        FLD_PROTO
    } field_t;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [7:0] data;
        field_t     field;
        logic       emit;
        logic       final_rec;
    } q_entry_t;

    // standard v5 record offsets
    function automatic field_t classify_offset(input logic [OffW-1:0] off);
        field_t f;
        begin
            case (off) inside
                [6'd0:6'd3]:   f = FLD_SRC_ADDR;
                [6'd4:6'd7]:   f = FLD_DST_ADDR;
                [6'd20:6'd23]: f = FLD_OCTETS;
                6'd32, 6'd33:  f = FLD_SRC_PORT;
                6'd34, 6'd35:  f = FLD_DST_PORT;
                6'd38:         f = FLD_PROTO;
                default:       f = FLD_NONE;
            endcase
            return f;
        end
    endfunction

endpackage

// ===== hw/rtl/nfv5_fifo.sv =====
`timescale 1ns / 1ps
// nfv5_fifo: short show-ahead queue between parser front and back
// depends on nfv5_pkg
module nfv5_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  nfv5_pkg::q_entry_t push_entry,
    output logic              full,
    output logic              q_valid,
    output nfv5_pkg::q_entry_t q_entry,
    input  logic              pop
);
    import nfv5_pkg::*;

    localparam int AddrW = $clog2(QueueDepth);
    localparam int CntW  = $clog2(QueueDepth + 1);

    q_entry_t           mem [QueueDepth];
    logic [AddrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CntW'(QueueDepth));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(QueueDepth))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/nfv5_front.sv =====
`timescale 1ns / 1ps
// nfv5_front: byte tracking, header checks and record byte classification
// depends on nfv5_pkg
module nfv5_front #(
    parameter int MAX_RECORDS = nfv5_pkg::MaxRecords
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [7:0]         s_data_byte,
    input  logic [15:0]        s_datagram_length,
    input  logic               s_last_byte,
    output logic               s_ready,
    input  logic               q_full,
    output logic               push,
    output nfv5_pkg::q_entry_t push_entry
);
    import nfv5_pkg::*;

    localparam int RecW = $clog2(MAX_RECORDS + 1);

    logic [15:0]     pos_reg, pos_next;
    logic            accepted_reg, accepted_next;
    logic [15:0]     version_reg, version_next;
    logic [15:0]     total_reg, total_next;
    logic [RecW-1:0] rec_num_reg, rec_num_next;
    logic [OffW-1:0] rec_off_reg, rec_off_next;
    logic            accept;
    logic [21:0]     expected_len;
    logic            header_ok;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    // 24 + 48 * count as shift-add
    assign expected_len = 22'(HdrBytes) + (22'(total_reg) << 5) + (22'(total_reg) << 4);
    assign header_ok    = (version_reg == 16'(NfVersion))
                       && (total_reg <= 16'(MAX_RECORDS))
                       && ({6'd0, s_datagram_length} == expected_len);

    always_comb begin
        pos_next      = pos_reg;
        accepted_next = accepted_reg;
        version_next  = version_reg;
        total_next    = total_reg;
        rec_num_next  = rec_num_reg;
        rec_off_next  = rec_off_reg;
        push          = 1'b0;
        push_entry    = '{data: s_data_byte, field: FLD_NONE, emit: 1'b0, final_rec: 1'b0};
        if (accept) begin
            if (pos_reg < 16'(HdrBytes)) begin
                if (pos_reg == 16'd0) begin
                    version_next = {s_data_byte, 8'd0};
                end else if (pos_reg == 16'd1) begin
                    version_next = {version_reg[15:8], s_data_byte};
                end else if (pos_reg == 16'd2) begin
                    total_next = {s_data_byte, 8'd0};
                end else if (pos_reg == 16'd3) begin
                    total_next = {total_reg[15:8], s_data_byte};
                end
                if (pos_reg == 16'(HdrBytes - 1)) begin
                    accepted_next = header_ok;
                    rec_num_next  = '0;
                    rec_off_next  = '0;
                end
            end else begin
                rec_off_next = (rec_off_reg == OffW'(RecBytes - 1)) ? '0 : rec_off_reg + 1'b1;
                if (accepted_reg && (16'(rec_num_reg) < total_reg)) begin
                    push_entry.field     = classify_offset(rec_off_reg);
                    push_entry.emit      = (rec_off_reg == OffW'(RecBytes - 1));
                    push_entry.final_rec = push_entry.emit
                                        && ((16'(rec_num_reg) + 16'd1) == total_reg);
                    push = (push_entry.field != FLD_NONE) || push_entry.emit;
                    if (push_entry.emit) begin
                        rec_num_next = rec_num_reg + 1'b1;
                    end
                end
            end
            if (s_last_byte) begin
                pos_next      = '0;
                accepted_next = 1'b0;
                version_next  = '0;
                total_next    = '0;
                rec_num_next  = '0;
                rec_off_next  = '0;
            end else if (pos_reg != 16'hFFFF) begin
                pos_next = pos_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            accepted_reg <= 1'b0;
            version_reg  <= '0;
            total_reg    <= '0;
            rec_num_reg  <= '0;
            rec_off_reg  <= '0;
        end else begin
            pos_reg      <= pos_next;
            accepted_reg <= accepted_next;
            version_reg  <= version_next;
            total_reg    <= total_next;
            rec_num_reg  <= rec_num_next;
            rec_off_reg  <= rec_off_next;
        end
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        accepted_reg |-> total_reg <= 16'(MAX_RECORDS))
        else $error("accepted datagram with too many records");
    a_recnum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        accepted_reg |-> 16'(rec_num_reg) <= total_reg)
        else $error("record number ran past record count");
    a_final_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_entry.final_rec |-> push_entry.emit)
        else $error("final flag on a byte that closes no record");

endmodule

// ===== hw/rtl/nfv5_back.sv =====
`timescale 1ns / 1ps
// nfv5_back: field assembly from classified bytes and result output register
// depends on nfv5_pkg
module nfv5_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  nfv5_pkg::q_entry_t q_entry,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_ip_protocol,
    output logic [31:0]        m_octet_count,
    output logic [31:0]        m_source_address,
    output logic [31:0]        m_destination_address,
    output logic [15:0]        m_source_port,
    output logic [15:0]        m_destination_port,
    output logic               m_final_record
);
    import nfv5_pkg::*;

    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [31:0] octets_reg;
    logic [15:0] src_port_reg;
    logic [15:0] dst_port_reg;
    logic [7:0]  proto_reg;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;
    logic        load_out;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = q_valid && (!q_entry.emit || out_free);
    assign load_out = pop && q_entry.emit;
    assign m_valid  = m_valid_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    // field shifters, every field fully rewritten once per record
    always_ff @(posedge aclk) begin
        if (pop) begin
            case (q_entry.field)
                FLD_SRC_ADDR: src_addr_reg <= {src_addr_reg[23:0], q_entry.data};
                FLD_DST_ADDR: dst_addr_reg <= {dst_addr_reg[23:0], q_entry.data};
                FLD_OCTETS:   octets_reg   <= {octets_reg[23:0], q_entry.data};
                FLD_SRC_PORT: src_port_reg <= {src_port_reg[7:0], q_entry.data};
                FLD_DST_PORT: dst_port_reg <= {dst_port_reg[7:0], q_entry.data};
                FLD_PROTO:    proto_reg    <= q_entry.data;
                default:      ;
            endcase
        end
        if (load_out) begin
            m_ip_protocol         <= proto_reg;
            m_octet_count         <= octets_reg;
            m_source_address      <= src_addr_reg;
            m_destination_address <= dst_addr_reg;
            m_source_port         <= src_port_reg;
            m_destination_port    <= dst_port_reg;
            m_final_record        <= q_entry.final_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/netflow_v5_record_parser_top.sv =====
`timescale 1ns / 1ps
// netflow_v5_record_parser_top: top level of the netflow v5 record parser
// depends on nfv5_pkg, nfv5_front, nfv5_fifo, nfv5_back
//
// Takes a received datagram one byte per transfer on the s_ channel and
// gives one transfer on the m_ channel for each complete 48-byte flow
// record of a datagram whose header passes its checks (version 5, record
// count at most MAX_RECORDS, length equal to 24 plus 48 times the count);
// a datagram that fails is dropped without any result. A transfer with
// s_last_byte set ends the datagram and parsing restarts with the next
// byte. The block takes one byte every clock while s_ready is high: the
// front tracks position and classifies bytes in the cycle they arrive, a
// four-entry queue holds classified bytes, and the back shifts them into
// the record fields and loads the output register when the byte that
// closes a record leaves the queue. s_ready drops only when the queue is
// full, which happens only while m_ready is held low with results pending.
module netflow_v5_record_parser_top #(
    parameter int MAX_RECORDS = nfv5_pkg::MaxRecords
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_datagram_length,
    input  logic        s_last_byte,
    // record output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_ip_protocol,
    output logic [31:0] m_octet_count,
    output logic [31:0] m_source_address,
    output logic [31:0] m_destination_address,
    output logic [15:0] m_source_port,
    output logic [15:0] m_destination_port,
    output logic        m_final_record
);
    import nfv5_pkg::*;

    // front to queue
    logic     push;
    q_entry_t push_entry;
    logic     q_full;
    // queue to back
    logic     q_valid;
    q_entry_t q_entry;
    logic     pop;

    // position tracking, header checks and byte classification
    nfv5_front #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_data_byte       (s_data_byte),
        .s_datagram_length (s_datagram_length),
        .s_last_byte       (s_last_byte),
        .s_ready           (s_ready),
        .q_full            (q_full),
        .push              (push),
        .push_entry        (push_entry)
    );

    // decouples byte intake from result stalls
    nfv5_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    // field assembly and output register
    nfv5_back u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .q_valid               (q_valid),
        .q_entry               (q_entry),
        .pop                   (pop),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_ip_protocol         (m_ip_protocol),
        .m_octet_count         (m_octet_count),
        .m_source_address      (m_source_address),
        .m_destination_address (m_destination_address),
        .m_source_port         (m_source_port),
        .m_destination_port    (m_destination_port),
        .m_final_record        (m_final_record)
    );

endmodule

// ===== dv/nfv5_record_checker.sv =====
`timescale 1ns / 1ps
// nfv5_record_checker: watches the byte and record channels of the netflow v5
// record parser, predicts each flow record and compares it field by field
// depends on nfv5_pkg
module nfv5_record_checker #(
    parameter int MAX_RECORDS = nfv5_pkg::MaxRecords
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_datagram_length,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_ip_protocol,
    input  logic [31:0] m_octet_count,
    input  logic [31:0] m_source_address,
    input  logic [31:0] m_destination_address,
    input  logic [15:0] m_source_port,
    input  logic [15:0] m_destination_port,
    input  logic        m_final_record,
    output int          fail_count,
    output int          records_pending
);
    import nfv5_pkg::*;

    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] octets;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        final_rec;
    } flow_record_t;

    flow_record_t expected_records[$];

    // parser image
    logic [15:0] byte_pos;
    logic        dgram_ok;
    logic [15:0] hdr_version;
    logic [15:0] rec_count;
    logic [5:0]  rec_index;
    logic [31:0] src_addr_acc;
    logic [31:0] dst_addr_acc;
    logic [31:0] octets_acc;
    logic [15:0] src_port_acc;
    logic [15:0] dst_port_acc;
    logic [7:0]  proto_acc;

    task automatic clear_parser();
        byte_pos     = '0;
        dgram_ok     = 1'b0;
        hdr_version  = '0;
        rec_count    = '0;
        rec_index    = '0;
        src_addr_acc = '0;
        dst_addr_acc = '0;
        octets_acc   = '0;
        src_port_acc = '0;
        dst_port_acc = '0;
        proto_acc    = '0;
    endtask

    task automatic track_datagram_byte(input logic [7:0] data, input logic [15:0] length,
                                       input logic is_last);
        int unsigned  rec_offset;
        flow_record_t rec;
        if (byte_pos < HdrBytes) begin
            case (byte_pos)
                16'd0: hdr_version = {data, 8'h00};
                16'd1: hdr_version = hdr_version | {8'h00, data};
                16'd2: rec_count = {data, 8'h00};
                16'd3: rec_count = rec_count | {8'h00, data};
                default: ;
            endcase
            // header verdict on its last byte, with the length carried by that byte
            if (byte_pos == HdrBytes - 1) begin
                dgram_ok = hdr_version == NfVersion && 32'(rec_count) <= MAX_RECORDS &&
                           32'(length) == HdrBytes + RecBytes * 32'(rec_count);
                rec_index = '0;
            end
        end else if (dgram_ok && 16'(rec_index) < rec_count) begin
            rec_offset = (32'(byte_pos) - HdrBytes) % RecBytes;
            if (rec_offset < 4)
                src_addr_acc = {src_addr_acc[23:0], data};
            else if (rec_offset < 8)
                dst_addr_acc = {dst_addr_acc[23:0], data};
            else if (rec_offset >= 20 && rec_offset < 24)
                octets_acc = {octets_acc[23:0], data};
            else if (rec_offset == 32 || rec_offset == 33)
                src_port_acc = {src_port_acc[7:0], data};
            else if (rec_offset == 34 || rec_offset == 35)
                dst_port_acc = {dst_port_acc[7:0], data};
            else if (rec_offset == 38)
                proto_acc = data;
            if (rec_offset == RecBytes - 1) begin
                rec.proto     = proto_acc;
                rec.octets    = octets_acc;
                rec.src_addr  = src_addr_acc;
                rec.dst_addr  = dst_addr_acc;
                rec.src_port  = src_port_acc;
                rec.dst_port  = dst_port_acc;
                rec.final_rec = (32'(rec_index) + 1) == 32'(rec_count);
                expected_records.push_back(rec);
                rec_index = rec_index + 6'd1;
            end
        end
        if (is_last)
            clear_parser();
        else if (byte_pos != 16'hFFFF)
            byte_pos = byte_pos + 16'd1;
    endtask

    task automatic check_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
        end
    endtask

    task automatic check_record();
        flow_record_t want;
        if (expected_records.size() == 0) begin
            fail_count++;
            $error("record transfer with none expected (src 0x%0h dst 0x%0h)",
                   m_source_address, m_destination_address);
            return;
        end
        want = expected_records.pop_front();
        check_field("ip_protocol", 32'(want.proto), 32'(m_ip_protocol));
        check_field("octet_count", want.octets, m_octet_count);
        check_field("source_address", want.src_addr, m_source_address);
        check_field("destination_address", want.dst_addr, m_destination_address);
        check_field("source_port", 32'(want.src_port), 32'(m_source_port));
        check_field("destination_port", 32'(want.dst_port), 32'(m_destination_port));
        check_field("final_record", 32'(want.final_rec), 32'(m_final_record));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            expected_records.delete();
        end else begin
            if (m_valid && m_ready)
                check_record();
            if (s_valid && s_ready)
                track_datagram_byte(s_data_byte, s_datagram_length, s_last_byte);
        end
        records_pending = expected_records.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: testbench top for the netflow v5 record parser; drives datagram
// bytes and record back-pressure, gives the verdict
// depends on nfv5_pkg, nfv5_record_checker, netflow_v5_record_parser_top
module tb_top;
    import nfv5_pkg::*;

    localparam int          TotalBytes     = 1750;
    localparam int          MinRandomBytes = 300;
    localparam int          DrainLimit     = 5000;
    localparam logic [15:0] Version5       = 16'(NfVersion);
    localparam logic [15:0] MaxCount       = 16'(MaxRecords);

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic [15:0] s_datagram_length;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_ip_protocol;
    logic [31:0] m_octet_count;
    logic [31:0] m_source_address;
    logic [31:0] m_destination_address;
    logic [15:0] m_source_port;
    logic [15:0] m_destination_port;
    logic        m_final_record;

    int fail_count;
    int records_pending;

    int burst_left;
    int ready_run_left = 0;
    int bytes_sent;

    netflow_v5_record_parser_top #(
        .MAX_RECORDS(MaxRecords)
    ) i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_data_byte           (s_data_byte),
        .s_datagram_length     (s_datagram_length),
        .s_last_byte           (s_last_byte),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_ip_protocol         (m_ip_protocol),
        .m_octet_count         (m_octet_count),
        .m_source_address      (m_source_address),
        .m_destination_address (m_destination_address),
        .m_source_port         (m_source_port),
        .m_destination_port    (m_destination_port),
        .m_final_record        (m_final_record)
    );

    // checker sits beside the block and only watches its ports
    nfv5_record_checker #(
        .MAX_RECORDS(MaxRecords)
    ) i_checker (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_data_byte           (s_data_byte),
        .s_datagram_length     (s_datagram_length),
        .s_last_byte           (s_last_byte),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_ip_protocol         (m_ip_protocol),
        .m_octet_count         (m_octet_count),
        .m_source_address      (m_source_address),
        .m_destination_address (m_destination_address),
        .m_source_port         (m_source_port),
        .m_destination_port    (m_destination_port),
        .m_final_record        (m_final_record),
        .fail_count            (fail_count),
        .records_pending       (records_pending)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // generous timeout for a sound run
    initial begin
        #10_000_000;
        $display("** netflow_v5_record_parser_top: FAILED **");
        $finish;
    end

    // receiver back-pressure: long open stretches, long stalls that fill the
    // internal queue and push back on s_ready, and short random flicker
    always @(negedge aclk) begin
        if (ready_run_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    m_ready        <= 1'b1;
                    ready_run_left <= $urandom_range(50, 300);
                end
                2: begin
                    m_ready        <= 1'b0;
                    ready_run_left <= $urandom_range(20, 80);
                end
                default: begin
                    m_ready        <= 1'($urandom_range(0, 1));
                    ready_run_left <= $urandom_range(1, 6);
                end
            endcase
        end else begin
            ready_run_left <= ready_run_left - 1;
        end
    end

    // datagram length that passes the header check for a given record count
    function automatic logic [15:0] v5_length(input logic [15:0] count);
        return 16'(HdrBytes + RecBytes * int'(count));
    endfunction

    // one byte transfer; entered and left at a falling edge. the sender mostly idles
    // between bursts of random length, now and then a long burst with no gaps
    task automatic send_byte(input logic [7:0] data, input logic [15:0] length,
                             input logic is_last);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 32);
        end
        s_valid           <= 1'b1;
        s_data_byte       <= data;
        s_datagram_length <= length;
        s_last_byte       <= is_last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    // whole datagram: version and record count in the first four bytes, the
    // checked length on the last header byte and another length elsewhere,
    // last-byte mark on the final byte sent
    task automatic send_datagram(input logic [15:0] version, input logic [15:0] count,
                                 input logic [15:0] checked_len,
                                 input logic [15:0] other_len, input int nbytes,
                                 input bit fill_fixed, input logic [7:0] fill_byte);
        logic [7:0] data;
        for (int pos = 0; pos < nbytes; pos++) begin
            case (pos)
                0: data = version[15:8];
                1: data = version[7:0];
                2: data = count[15:8];
                3: data = count[7:0];
                default: data = fill_fixed ? fill_byte : 8'($urandom_range(0, 255));
            endcase
            send_byte(data, (pos == HdrBytes - 1) ? checked_len : other_len,
                      pos == nbytes - 1);
        end
    endtask

    // hold the sender off until every predicted record has been taken
    task automatic drain_records();
        s_valid <= 1'b0;
        wait (records_pending == 0);
        @(negedge aclk);
        burst_left = 0;
    endtask

    initial begin
        int          random_start;
        int          nbytes;
        int          waited;
        logic [15:0] version;
        logic [15:0] count;
        logic [15:0] length;
        logic [15:0] other;

        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_data_byte       = '0;
        s_datagram_length = '0;
        s_last_byte       = 1'b0;
        burst_left        = 0;
        bytes_sent        = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: record bytes all ones and all zeros
        send_datagram(Version5, 16'd1, v5_length(16'd1), v5_length(16'd1), 72, 1'b1, 8'hFF);
        send_datagram(Version5, 16'd1, v5_length(16'd1), v5_length(16'd1), 72, 1'b1, 8'h00);
        // largest record count allowed
        send_datagram(Version5, MaxCount, v5_length(MaxCount), v5_length(MaxCount),
                      HdrBytes + RecBytes * MaxRecords, 1'b0, 8'h00);
        // header only, no records
        send_datagram(Version5, 16'd0, v5_length(16'd0), v5_length(16'd0), HdrBytes,
                      1'b0, 8'h00);
        // one record over the limit, length consistent; one record's worth of bytes
        send_datagram(Version5, MaxCount + 16'd1, v5_length(MaxCount + 16'd1),
                      v5_length(MaxCount + 16'd1), 72, 1'b0, 8'h00);
        // wrong versions
        send_datagram(16'd4, 16'd1, v5_length(16'd1), v5_length(16'd1), 72, 1'b0, 8'h00);
        send_datagram(16'h0105, 16'd1, v5_length(16'd1), v5_length(16'd1), 72, 1'b0, 8'h00);
        send_datagram(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 1'b0, 8'h00);
        // count with its high byte set
        send_datagram(Version5, 16'h0101, v5_length(16'd1), v5_length(16'd1), 72,
                      1'b0, 8'h00);
        // length off by one
        send_datagram(Version5, 16'd1, v5_length(16'd1) + 16'd1, v5_length(16'd1) + 16'd1,
                      72, 1'b0, 8'h00);
        // length differs mid-datagram: only the one on the last header byte counts
        send_datagram(Version5, 16'd2, v5_length(16'd2), 16'h0000, 120, 1'b0, 8'h00);
        send_datagram(Version5, 16'd1, 16'hFFFF, v5_length(16'd1), 72, 1'b0, 8'h00);
        // short datagrams ending inside the header
        send_datagram(Version5, 16'd1, v5_length(16'd1), v5_length(16'd1), 1, 1'b0, 8'h00);
        send_datagram(Version5, 16'd1, v5_length(16'd1), v5_length(16'd1), 11, 1'b0, 8'h00);
        send_datagram(Version5, 16'd1, v5_length(16'd1), v5_length(16'd1), HdrBytes - 1,
                      1'b0, 8'h00);
        // accepted header, cut right after it
        send_datagram(Version5, 16'd3, v5_length(16'd3), v5_length(16'd3), HdrBytes,
                      1'b0, 8'h00);
        // second record cut off part way
        send_datagram(Version5, 16'd2, v5_length(16'd2), v5_length(16'd2),
                      HdrBytes + RecBytes + 30, 1'b0, 8'h00);
        // trailing bytes after the counted records
        send_datagram(Version5, 16'd1, v5_length(16'd1), v5_length(16'd1), 72 + 20,
                      1'b0, 8'h00);

        // let the record side empty completely before the random part
        drain_records();

        // random: mostly well-formed datagrams with random content, some cut
        // short or padded or with a stray length, the rest noise headers
        random_start = bytes_sent;
        while (bytes_sent < TotalBytes || bytes_sent - random_start < MinRandomBytes)
        begin
            if ($urandom_range(0, 14) == 0)
                drain_records();
            if ($urandom_range(0, 9) < 7) begin
                count = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, MaxRecords))
                                                     : 16'($urandom_range(0, 4));
                length = v5_length(count);
                other  = length;
                nbytes = int'(length);
                case ($urandom_range(0, 9))
                    0: nbytes = int'($urandom_range(1, 32'(length)));
                    1: nbytes = int'(length) + int'($urandom_range(1, 60));
                    2: other = 16'($urandom);
                    default: ;
                endcase
                send_datagram(Version5, count, length, other, nbytes, 1'b0, 8'h00);
            end else begin
                version = $urandom_range(0, 1) ? Version5 : 16'($urandom);
                count   = $urandom_range(0, 1) ? 16'($urandom_range(0, MaxRecords + 10))
                                               : 16'($urandom);
                length  = $urandom_range(0, 1) ? v5_length(count) : 16'($urandom);
                send_datagram(version, count, length, 16'($urandom),
                              int'($urandom_range(1, 120)), 1'b0, 8'h00);
            end
        end
        s_valid <= 1'b0;

        // wait for the last records, bounded, then a short tail for strays
        waited = 0;
        while (records_pending != 0 && waited < DrainLimit) begin
            @(posedge aclk);
            waited++;
        end
        repeat (16) @(posedge aclk);
        if (records_pending != 0)
            $error("%0d expected records never arrived", records_pending);

        if (fail_count == 0 && records_pending == 0)
            $display("** netflow_v5_record_parser_top: PASSED **");
        else
            $display("** netflow_v5_record_parser_top: FAILED **");
        $finish;
    end

endmodule
